// ----- src/fpalu_pkg.sv -----
// ----------------------------------------------------------------------------
// fpalu_pkg
// Types and constants shared by the fixed-point ALU modules.
// ----------------------------------------------------------------------------
package fpalu_pkg;

   localparam int DATA_WIDTH           = 32;
   localparam int OP_WIDTH             = 4;
   localparam int FRACTION_BITS_DEFAULT = 8;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_LT       = 4'd5,
      OP_GE       = 4'd6,
      OP_LE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_TO_INT   = 4'd14,
      OP_FROM_INT = 4'd15
   } op_type;

   // Sideband that travels alongside each item through the cell row.
   typedef struct packed {
      logic                  valid;
      logic                  negate;
      logic                  div_zero;
      logic                  is_div;
      logic [DATA_WIDTH-1:0] value;
      logic                  flag;
   } tag_type;

endpackage

// ----- src/fpalu_div_cell.sv -----
// ----------------------------------------------------------------------------
// fpalu_div_cell
// One restoring-division step: produces one quotient bit and hands the
// partial remainder, quotient and item tag to the next cell.
// ----------------------------------------------------------------------------
module fpalu_div_cell
   import fpalu_pkg::*;
#(
   parameter int NUM_WIDTH = 64,
   parameter int DEN_WIDTH = 32,
   parameter int STEP      = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [NUM_WIDTH-1:0] num_in,
   input  logic [DEN_WIDTH:0]   rem_in,
   input  logic [NUM_WIDTH-1:0] quo_in,
   input  logic [DEN_WIDTH-1:0] den_in,
   input  tag_type              tag_in,
   output logic [NUM_WIDTH-1:0] num_out,
   output logic [DEN_WIDTH:0]   rem_out,
   output logic [NUM_WIDTH-1:0] quo_out,
   output logic [DEN_WIDTH-1:0] den_out,
   output tag_type              tag_out
);

   logic [NUM_WIDTH-1:0] num_ff;
   logic [DEN_WIDTH:0]   rem_ff, rem_in_v;
   logic [NUM_WIDTH-1:0] quo_ff, quo_in_v;
   logic [DEN_WIDTH-1:0] den_ff;
   tag_type              tag_ff;
   logic [DEN_WIDTH+1:0] shifted, diff;

   always_comb begin
      shifted  = {rem_in, num_in[NUM_WIDTH-1-STEP]};
      diff     = shifted - {2'b00, den_in};
      quo_in_v = quo_in;
      if (!diff[DEN_WIDTH+1]) begin
         rem_in_v = diff[DEN_WIDTH:0];
         quo_in_v[NUM_WIDTH-1-STEP] = 1'b1;
      end else begin
         rem_in_v = shifted[DEN_WIDTH:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff.valid <= tag_in.valid;
      end
      tag_ff.negate   <= tag_in.negate;
      tag_ff.div_zero <= tag_in.div_zero;
      tag_ff.is_div   <= tag_in.is_div;
      tag_ff.value    <= tag_in.value;
      tag_ff.flag     <= tag_in.flag;
      num_ff <= num_in;
      rem_ff <= rem_in_v;
      quo_ff <= quo_in_v;
      den_ff <= den_in;
   end

   assign num_out = num_ff;
   assign rem_out = rem_ff;
   assign quo_out = quo_ff;
   assign den_out = den_ff;
   assign tag_out = tag_ff;

endmodule

// ----- src/fpalu_front.sv -----
// ----------------------------------------------------------------------------
// fpalu_front
// First stage: computes all results but MUL and DIV, forms the registered
// multiplier product and prepares the magnitudes for the division row.
// ----------------------------------------------------------------------------
module fpalu_front
   import fpalu_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    valid_in,
   input  logic [OP_WIDTH-1:0]     op_in,
   input  logic signed [DATA_WIDTH-1:0] a_in,
   input  logic signed [DATA_WIDTH-1:0] b_in,
   output tag_type                 tag_out,
   output logic                    is_mul_out,
   output logic signed [2*DATA_WIDTH-1:0] prod_out,
   output logic [2*DATA_WIDTH-1:0] num_out,
   output logic [DATA_WIDTH-1:0]   den_out
);

   localparam int W = DATA_WIDTH;

   tag_type              tag_ff, tag_in;
   logic                 is_mul_ff;
   logic signed [2*W-1:0] prod_ff;
   logic [2*W-1:0]       num_ff, num_in;
   logic [W-1:0]         den_ff, den_in;
   logic [W-1:0]         ma, mb;
   op_type               op;

   always_comb begin
      op = op_type'(op_in);
      ma = a_in[W-1] ? (~a_in + 1'b1) : a_in;
      mb = b_in[W-1] ? (~b_in + 1'b1) : b_in;
      num_in = {{W{1'b0}}, ma} << FRACTION_BITS;
      den_in = mb;
      tag_in.valid    = valid_in;
      tag_in.negate   = a_in[W-1] ^ b_in[W-1];
      tag_in.div_zero = 1'b0;
      tag_in.is_div   = 1'b0;
      tag_in.value    = '0;
      tag_in.flag     = 1'b0;
      unique case (op)
         OP_ADD:      tag_in.value = a_in + b_in;
         OP_SUB:      tag_in.value = a_in - b_in;
         OP_MUL:      tag_in.value = '0;
         OP_DIV: begin
            tag_in.is_div   = (b_in != '0);
            tag_in.div_zero = (b_in == '0);
         end
         OP_GT:       tag_in.flag  = (a_in > b_in);
         OP_LT:       tag_in.flag  = (a_in < b_in);
         OP_GE:       tag_in.flag  = (a_in >= b_in);
         OP_LE:       tag_in.flag  = (a_in <= b_in);
         OP_EQ:       tag_in.flag  = (a_in == b_in);
         OP_NE:       tag_in.flag  = (a_in != b_in);
         OP_MIN:      tag_in.value = (a_in < b_in) ? a_in : b_in;
         OP_MAX:      tag_in.value = (a_in > b_in) ? a_in : b_in;
         OP_INC:      tag_in.value = a_in + 1'b1;
         OP_DEC:      tag_in.value = a_in - 1'b1;
         OP_TO_INT:   tag_in.value = a_in >>> FRACTION_BITS;
         OP_FROM_INT: tag_in.value = a_in << FRACTION_BITS;
         default:     tag_in.value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff.valid <= tag_in.valid;
      end
      tag_ff.negate   <= tag_in.negate;
      tag_ff.div_zero <= tag_in.div_zero;
      tag_ff.is_div   <= tag_in.is_div;
      tag_ff.value    <= tag_in.value;
      tag_ff.flag     <= tag_in.flag;
      is_mul_ff <= (op == OP_MUL);
      prod_ff   <= a_in * b_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
   end

   assign tag_out    = tag_ff;
   assign is_mul_out = is_mul_ff;
   assign prod_out   = prod_ff;
   assign num_out    = num_ff;
   assign den_out    = den_ff;

endmodule

// ----- src/fixed_point_alu_top.sv -----
// ----------------------------------------------------------------------------
// fixed_point_alu_top
// Signed fixed-point ALU with a pipelined division row of cells.
// ----------------------------------------------------------------------------
// Usage: drive req_operation, req_operand_a and req_operand_b with start high
// for one cycle to issue an item. busy is never raised, so an item may be
// issued in every clock cycle.
// Every item, whatever its operation, passes through the same stages from start
// to the rsp_valid strobe: one front stage, one division cell per quotient bit
// of the 64-bit widened dividend, and one output stage; the throughput is one
// item per cycle.
// Each result appears on rsp_result_value, rsp_compare_flag and
// rsp_divide_by_zero for exactly one cycle with rsp_valid high, in issue order.
// The receiver cannot stall the block.
// Synchronous reset clears all valid bits in the pipeline; items in flight
// are dropped and no result is shown until new items are issued.
// ----------------------------------------------------------------------------
module fixed_point_alu_top
   import fpalu_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [OP_WIDTH-1:0]          req_operation,
   input  logic signed [DATA_WIDTH-1:0] req_operand_a,
   input  logic signed [DATA_WIDTH-1:0] req_operand_b,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_result_value,
   output logic                         rsp_compare_flag,
   output logic                         rsp_divide_by_zero
);

   localparam int W  = DATA_WIDTH;
   localparam int NW = 2 * DATA_WIDTH;

   tag_type               tag_s [0:NW];
   logic [NW-1:0]         num_s [0:NW];
   logic [W:0]            rem_s [0:NW];
   logic [NW-1:0]         quo_s [0:NW];
   logic [W-1:0]          den_s [0:NW];
   logic                  is_mul;
   logic signed [NW-1:0]  prod;
   logic signed [NW-1:0]  prod_sh;

   // The product is registered in the front stage and reaches the output
   // through its own delay line, which runs beside the division row.
   logic [W-1:0]          mul_ff [0:NW-1];

   fpalu_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .valid_in   (start),
      .op_in      (req_operation),
      .a_in       (req_operand_a),
      .b_in       (req_operand_b),
      .tag_out    (tag_s[0]),
      .is_mul_out (is_mul),
      .prod_out   (prod),
      .num_out    (num_s[0]),
      .den_out    (den_s[0])
   );

   assign rem_s[0] = '0;
   assign quo_s[0] = '0;
   assign prod_sh  = prod >>> FRACTION_BITS;

   always_ff @(posedge clock) begin
      mul_ff[0] <= is_mul ? prod_sh[W-1:0] : '0;
      for (int i = 1; i < NW; i++) begin
         mul_ff[i] <= mul_ff[i-1];
      end
   end

   for (genvar g = 0; g < NW; g++) begin : g_cell
      fpalu_div_cell #(.NUM_WIDTH(NW), .DEN_WIDTH(W), .STEP(g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .num_in  (num_s[g]),
         .rem_in  (rem_s[g]),
         .quo_in  (quo_s[g]),
         .den_in  (den_s[g]),
         .tag_in  (tag_s[g]),
         .num_out (num_s[g+1]),
         .rem_out (rem_s[g+1]),
         .quo_out (quo_s[g+1]),
         .den_out (den_s[g+1]),
         .tag_out (tag_s[g+1])
      );
   end

   tag_type       tag_end;
   logic [W-1:0]  quo_low, div_val;
   logic          valid_ff;
   logic [W-1:0]  value_ff;
   logic          flag_ff, dz_ff;

   always_comb begin
      tag_end = tag_s[NW];
      quo_low = quo_s[NW][W-1:0];
      div_val = tag_end.negate ? (~quo_low + 1'b1) : quo_low;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tag_end.valid;
      end
      value_ff <= tag_end.is_div ? div_val : (tag_end.value | mul_ff[NW-1]);
      flag_ff  <= tag_end.flag;
      dz_ff    <= tag_end.div_zero;
   end

   assign busy               = 1'b0;
   assign rsp_valid          = valid_ff;
   assign rsp_result_value   = value_ff;
   assign rsp_compare_flag   = flag_ff;
   assign rsp_divide_by_zero = dz_ff;

endmodule
